### design/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
// no dependencies
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int POOL_BYTES   = 65536;
    localparam int ALIGN_BYTES  = 8;
    localparam int HEADER_BYTES = 16;
    localparam int SLOT_GRAIN   = 8;
    localparam int GRAIN_SHIFT  = $clog2(SLOT_GRAIN);
    localparam int STORE_DEPTH  = POOL_BYTES / SLOT_GRAIN;
    localparam int SLOT_W       = $clog2(STORE_DEPTH);
    localparam int LINK_W       = SLOT_W + 1;
    localparam int SIZE_W       = 17;
    localparam int OFF_W        = 16;
    localparam int CNT_W        = 32;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [OFF_W-1:0]  off_t;

    localparam link_t NO_BLOCK = link_t'(STORE_DEPTH);

    localparam logic [1:0] CMD_ALLOC      = 2'd0;
    localparam logic [1:0] CMD_ALLOC_ZERO = 2'd1;
    localparam logic [1:0] CMD_FREE       = 2'd2;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_FRAG     = 2'd1;
    localparam logic [1:0] ERR_OVERRUN  = 2'd2;
    localparam logic [1:0] ERR_BAD_FREE = 2'd3;

    localparam logic [1:0] CFG_POOL_SIZE = 2'd0;
    localparam logic [1:0] CFG_CLEAR     = 2'd1;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_SPLIT,
        ST_A_RELINK,
        ST_A_UNLINK,
        ST_F_RD,
        ST_F_CHK,
        ST_F_WALK_RD,
        ST_F_WALK_CHK,
        ST_F_UNLINK,
        ST_F_PUSH0,
        ST_F_PUSH1,
        ST_DONE
    } ffba_state_t;

    typedef struct packed {
        logic       ok;
        off_t       payload_offset;
        size_t      granted_size;
        logic [1:0] error_code;
        logic       zero_fill;
        size_t      used_bytes;
    } ffba_result_t;

endpackage

### design/first_fit_block_allocator.sv
// An allocation reads and checks each free-list block in turn until the first fit, then
// unlinks it, or splits it and relinks the rest. A free checks its header, then scans the
// whole free list for neighbors, unlinks each one it merges with and pushes the merged
// block on the list head. The header rams have one read port, so every list step is a read
// followed by a check. After reset and after every pool_size write, a clearing pass runs
// through the in-use store; requests stall during it, configuration writes are taken.
// Results sit in an output register, so the next request is accepted while one waits.
// uses ffba_pkg and ffba_engine
`timescale 1ns / 1ps

module first_fit_block_allocator import ffba_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [16:0] request_size,
    input  logic [15:0] block_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [15:0] payload_offset,
    output logic [16:0] granted_size,
    output logic [1:0]  error_code,
    output logic        zero_fill,
    output logic [16:0] used_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    size_t        pool_reg;
    logic         clear_reg;
    logic         out_valid_reg;
    ffba_result_t out_reg;
    ffba_result_t eng_res;
    logic         eng_done;
    logic         res_free;
    logic         cfg_wr;
    logic         pool_init;
    size_t        pool_clamped;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign pool_init = cfg_wr && (cfg_index == CFG_POOL_SIZE);

    always_comb
    begin
        pool_clamped = cfg_data;
        if (cfg_data < SIZE_W'(HEADER_BYTES))
        begin
            pool_clamped = SIZE_W'(HEADER_BYTES);
        end
        else if (cfg_data > SIZE_W'(POOL_BYTES))
        begin
            pool_clamped = SIZE_W'(POOL_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg  <= SIZE_W'(POOL_BYTES);
            clear_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_POOL_SIZE: pool_reg  <= pool_clamped;
                CFG_CLEAR:     clear_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign res_free = !out_valid_reg || !out_stall;

    ffba_engine u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .init(pool_init),
        .pool_size(pool_reg),
        .clear_on_alloc(clear_reg),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .request_size(request_size),
        .block_offset(block_offset),
        .res_free(res_free),
        .res_done(eng_done),
        .res(eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            out_reg <= eng_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = out_reg.ok;
    assign payload_offset = out_reg.payload_offset;
    assign granted_size   = out_reg.granted_size;
    assign error_code     = out_reg.error_code;
    assign zero_fill      = out_reg.zero_fill;
    assign used_bytes     = out_reg.used_bytes;

endmodule

### design/ffba_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/ffba_engine.sv
// command sequencer: walks the free list held in the header rams, splits,
// coalesces and relinks blocks; uses ffba_pkg and ffba_ram
`timescale 1ns / 1ps

module ffba_engine import ffba_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         init,
    input  size_t        pool_size,
    input  logic         clear_on_alloc,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   cmd,
    input  size_t        request_size,
    input  off_t         block_offset,
    input  logic         res_free,
    output logic         res_done,
    output ffba_result_t res
);

    ffba_state_t state_reg, state_next;

    link_t        cur_reg, nx_reg, pv_reg, head_reg;
    slot_t        f_reg, r_reg, clr_cnt_reg;
    size_t        fsize_reg, want_reg, req_reg, sz_reg, used_reg;
    logic         zero_reg;
    logic [CNT_W-1:0] alloc_cnt_reg, free_cnt_reg;
    logic [2:0]   err_flags_reg;
    ffba_result_t res_reg;

    slot_t rd_addr;
    size_t size_rd;
    link_t next_rd, prev_rd;
    logic  inuse_rd;

    logic  size_we, next_we, prev_we, inuse_we;
    slot_t size_wa, next_wa, prev_wa, inuse_wa;
    size_t size_wd;
    link_t next_wd, prev_wd;
    logic  inuse_wd;

    logic  accept;
    size_t want_calc;
    off_t  hdr_off;
    logic  bad_off;
    logic  fit;
    size_t leftover;
    slot_t r_calc;
    off_t  f_base, n_base;
    logic [SIZE_W:0] f_end, n_end;
    logic  merge_hi, merge_lo;

    ffba_ram #(.WIDTH(SIZE_W), .DEPTH(STORE_DEPTH)) u_size_ram (
        .clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_wd),
        .raddr(rd_addr), .rdata(size_rd)
    );
    ffba_ram #(.WIDTH(LINK_W), .DEPTH(STORE_DEPTH)) u_next_ram (
        .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
        .raddr(rd_addr), .rdata(next_rd)
    );
    ffba_ram #(.WIDTH(LINK_W), .DEPTH(STORE_DEPTH)) u_prev_ram (
        .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
        .raddr(rd_addr), .rdata(prev_rd)
    );
    ffba_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_inuse_ram (
        .clk(clk), .we(inuse_we), .waddr(inuse_wa), .wdata(inuse_wd),
        .raddr(rd_addr), .rdata(inuse_rd)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // a rounded size past the 17-bit range saturates so that no block fits
    always_comb
    begin
        logic [SIZE_W:0] sum;
        logic [SIZE_W:0] rounded;
        sum       = {1'b0, request_size} + (SIZE_W+1)'(ALIGN_BYTES - 1);
        rounded   = sum & ~((SIZE_W+1)'(ALIGN_BYTES - 1));
        want_calc = rounded[SIZE_W] ? '1 : rounded[SIZE_W-1:0];
    end

    // offset checks for a free request
    assign hdr_off = block_offset - OFF_W'(HEADER_BYTES);
    assign bad_off = (block_offset < OFF_W'(HEADER_BYTES))
                  || ({1'b0, hdr_off} >= pool_size)
                  || (hdr_off[GRAIN_SHIFT-1:0] != '0);

    assign fit      = (size_rd >= want_reg);
    assign leftover = size_rd - want_reg;
    assign r_calc   = cur_reg[SLOT_W-1:0] + SLOT_W'(HEADER_BYTES / SLOT_GRAIN)
                    + want_reg[SLOT_W+GRAIN_SHIFT-1:GRAIN_SHIFT];

    assign f_base   = OFF_W'(f_reg) << GRAIN_SHIFT;
    assign n_base   = OFF_W'(cur_reg[SLOT_W-1:0]) << GRAIN_SHIFT;
    assign f_end    = (SIZE_W+1)'(f_base) + (SIZE_W+1)'(HEADER_BYTES)
                    + (SIZE_W+1)'(fsize_reg);
    assign n_end    = (SIZE_W+1)'(n_base) + (SIZE_W+1)'(HEADER_BYTES)
                    + (SIZE_W+1)'(size_rd);
    assign merge_hi = (f_end == (SIZE_W+1)'(n_base));
    assign merge_lo = !merge_hi && (n_end == (SIZE_W+1)'(f_base));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:       state_next = ST_CLEAR;
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SLOT_W'(STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd) inside
                        CMD_ALLOC, CMD_ALLOC_ZERO: state_next = ST_A_RD;
                        CMD_FREE:  state_next = bad_off ? ST_DONE : ST_F_RD;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_A_RD:       state_next = (cur_reg == NO_BLOCK) ? ST_DONE : ST_A_CHK;
            ST_A_CHK:
            begin
                if (!fit)
                begin
                    state_next = ST_A_RD;
                end
                else if (leftover > SIZE_W'(HEADER_BYTES))
                begin
                    state_next = ST_A_SPLIT;
                end
                else
                begin
                    state_next = ST_A_UNLINK;
                end
            end
            ST_A_SPLIT:    state_next = ST_A_RELINK;
            ST_A_RELINK:   state_next = ST_DONE;
            ST_A_UNLINK:   state_next = ST_DONE;
            ST_F_RD:       state_next = ST_F_CHK;
            ST_F_CHK:      state_next = inuse_rd ? ST_F_WALK_RD : ST_DONE;
            ST_F_WALK_RD:
                state_next = (cur_reg == NO_BLOCK) ? ST_F_PUSH0 : ST_F_WALK_CHK;
            ST_F_WALK_CHK:
                state_next = (merge_hi || merge_lo) ? ST_F_UNLINK : ST_F_WALK_RD;
            ST_F_UNLINK:   state_next = ST_F_WALK_RD;
            ST_F_PUSH0:    state_next = ST_F_PUSH1;
            ST_F_PUSH1:    state_next = ST_DONE;
            ST_DONE:       state_next = res_free ? ST_IDLE : ST_DONE;
            default:       state_next = ST_INIT;
        endcase
        if (init)
        begin
            state_next = ST_INIT;
        end
    end

    // ram controls and result strobe
    always_comb
    begin
        rd_addr  = (state_reg == ST_F_RD) ? f_reg : cur_reg[SLOT_W-1:0];
        size_we  = 1'b0;
        size_wa  = cur_reg[SLOT_W-1:0];
        size_wd  = want_reg;
        next_we  = 1'b0;
        next_wa  = pv_reg[SLOT_W-1:0];
        next_wd  = nx_reg;
        prev_we  = 1'b0;
        prev_wa  = nx_reg[SLOT_W-1:0];
        prev_wd  = pv_reg;
        inuse_we = 1'b0;
        inuse_wa = cur_reg[SLOT_W-1:0];
        inuse_wd = 1'b1;
        res_done = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                size_we = 1'b1;
                size_wa = '0;
                size_wd = pool_size - SIZE_W'(HEADER_BYTES);
                next_we = 1'b1;
                next_wa = '0;
                next_wd = NO_BLOCK;
                prev_we = 1'b1;
                prev_wa = '0;
                prev_wd = NO_BLOCK;
            end
            ST_CLEAR:
            begin
                inuse_we = 1'b1;
                inuse_wa = clr_cnt_reg;
                inuse_wd = 1'b0;
            end
            ST_A_SPLIT:
            begin
                size_we = 1'b1;
                size_wa = r_reg;
                size_wd = sz_reg - want_reg - SIZE_W'(HEADER_BYTES);
                next_we = 1'b1;
                next_wa = r_reg;
                next_wd = nx_reg;
                prev_we = 1'b1;
                prev_wa = r_reg;
                prev_wd = pv_reg;
            end
            ST_A_RELINK:
            begin
                size_we  = 1'b1;
                next_we  = (pv_reg != NO_BLOCK);
                next_wd  = LINK_W'(r_reg);
                prev_we  = (nx_reg != NO_BLOCK);
                prev_wd  = LINK_W'(r_reg);
                inuse_we = 1'b1;
            end
            ST_A_UNLINK:
            begin
                next_we  = (pv_reg != NO_BLOCK);
                prev_we  = (nx_reg != NO_BLOCK);
                inuse_we = 1'b1;
            end
            ST_F_CHK:
            begin
                inuse_we = inuse_rd;
                inuse_wa = f_reg;
                inuse_wd = 1'b0;
            end
            ST_F_UNLINK:
            begin
                next_we = (pv_reg != NO_BLOCK);
                prev_we = (nx_reg != NO_BLOCK);
            end
            ST_F_PUSH0:
            begin
                size_we = 1'b1;
                size_wa = f_reg;
                size_wd = fsize_reg;
                next_we = 1'b1;
                next_wa = f_reg;
                next_wd = head_reg;
                prev_we = 1'b1;
                prev_wa = f_reg;
                prev_wd = NO_BLOCK;
            end
            ST_F_PUSH1:
            begin
                prev_we = (nx_reg != NO_BLOCK);
                prev_wd = LINK_W'(f_reg);
            end
            ST_DONE:       res_done = res_free;
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res            = res_reg;
        res.used_bytes = used_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            head_reg      <= '0;
            used_reg      <= '0;
            alloc_cnt_reg <= '0;
            free_cnt_reg  <= '0;
            err_flags_reg <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_INIT:
                begin
                    head_reg    <= '0;
                    used_reg    <= '0;
                    clr_cnt_reg <= '0;
                end
                ST_CLEAR:      clr_cnt_reg <= clr_cnt_reg + 1'b1;
                ST_IDLE:
                begin
                    if (accept && (cmd == CMD_ALLOC || cmd == CMD_ALLOC_ZERO))
                    begin
                        alloc_cnt_reg <= alloc_cnt_reg + 1'b1;
                    end
                    if (accept && cmd == CMD_FREE)
                    begin
                        free_cnt_reg <= free_cnt_reg + 1'b1;
                        if (bad_off)
                        begin
                            err_flags_reg[2] <= 1'b1;
                        end
                    end
                end
                ST_A_RD:
                begin
                    if (cur_reg == NO_BLOCK)
                    begin
                        if ((pool_size - used_reg) > req_reg)
                        begin
                            err_flags_reg[0] <= 1'b1;
                        end
                        else
                        begin
                            err_flags_reg[1] <= 1'b1;
                        end
                    end
                end
                ST_A_SPLIT:
                begin
                    if (head_reg == cur_reg)
                    begin
                        head_reg <= LINK_W'(r_reg);
                    end
                end
                ST_A_RELINK:
                    used_reg <= used_reg + SIZE_W'(HEADER_BYTES) + want_reg;
                ST_A_UNLINK:
                begin
                    used_reg <= used_reg + SIZE_W'(HEADER_BYTES) + sz_reg;
                    if (pv_reg == NO_BLOCK)
                    begin
                        head_reg <= nx_reg;
                    end
                end
                ST_F_CHK:
                begin
                    if (inuse_rd)
                    begin
                        used_reg <= used_reg - SIZE_W'(HEADER_BYTES) - size_rd;
                    end
                    else
                    begin
                        err_flags_reg[2] <= 1'b1;
                    end
                end
                ST_F_UNLINK:
                begin
                    if (pv_reg == NO_BLOCK)
                    begin
                        head_reg <= nx_reg;
                    end
                end
                ST_F_PUSH0:    head_reg <= LINK_W'(f_reg);
                default:
                begin
                end
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_reg  <= request_size;
                    want_reg <= want_calc;
                    zero_reg <= (cmd == CMD_ALLOC_ZERO);
                    cur_reg  <= head_reg;
                    f_reg    <= hdr_off[OFF_W-1:GRAIN_SHIFT];
                    res_reg.ok             <= 1'b0;
                    res_reg.payload_offset <= '0;
                    res_reg.granted_size   <= '0;
                    res_reg.zero_fill      <= 1'b0;
                    res_reg.used_bytes     <= '0;
                    res_reg.error_code     <= (cmd == CMD_FREE && bad_off)
                                            ? ERR_BAD_FREE : ERR_NONE;
                end
            end
            ST_A_RD:
            begin
                if (cur_reg == NO_BLOCK)
                begin
                    res_reg.error_code <= ((pool_size - used_reg) > req_reg)
                                        ? ERR_FRAG : ERR_OVERRUN;
                end
            end
            ST_A_CHK:
            begin
                sz_reg <= size_rd;
                nx_reg <= next_rd;
                pv_reg <= prev_rd;
                r_reg  <= r_calc;
                if (!fit)
                begin
                    cur_reg <= next_rd;
                end
            end
            ST_A_RELINK, ST_A_UNLINK:
            begin
                res_reg.ok             <= 1'b1;
                res_reg.payload_offset <= (OFF_W'(cur_reg[SLOT_W-1:0]) << GRAIN_SHIFT)
                                        + OFF_W'(HEADER_BYTES);
                res_reg.granted_size   <= (state_reg == ST_A_RELINK) ? want_reg : sz_reg;
                res_reg.zero_fill      <= zero_reg || clear_on_alloc;
            end
            ST_F_CHK:
            begin
                fsize_reg <= size_rd;
                cur_reg   <= head_reg;
                if (!inuse_rd)
                begin
                    res_reg.error_code <= ERR_BAD_FREE;
                end
            end
            ST_F_WALK_CHK:
            begin
                nx_reg <= next_rd;
                pv_reg <= prev_rd;
                if (merge_hi)
                begin
                    fsize_reg <= fsize_reg + SIZE_W'(HEADER_BYTES) + size_rd;
                end
                else if (merge_lo)
                begin
                    fsize_reg <= size_rd + SIZE_W'(HEADER_BYTES) + fsize_reg;
                    f_reg     <= cur_reg[SLOT_W-1:0];
                end
                else
                begin
                    cur_reg <= next_rd;
                end
            end
            ST_F_UNLINK:   cur_reg <= nx_reg;
            ST_F_PUSH0:    nx_reg <= head_reg;
            ST_F_PUSH1:    res_reg.ok <= 1'b1;
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_done |-> res_free && state_reg == ST_DONE)
        else $error("result issued while output register busy");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_RD || state_reg == ST_F_RD || state_reg == ST_F_WALK_RD)
        |-> !size_we && !next_we && !prev_we && !inuse_we)
        else $error("header ram written during a list read");

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> used_reg <= pool_size)
        else $error("used bytes exceed pool size");

    a_init_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        init |=> state_reg == ST_INIT && !res_done)
        else $error("pool rebuild not started");
`endif

endmodule

### tb/sv/tb_first_fit_block_allocator.sv
// self-checking testbench for first_fit_block_allocator: directed table, then random
// alloc/free traffic over several pool settings, checked against an in-bench allocator model
// depends on ffba_pkg and the first_fit_block_allocator rtl
`timescale 1ns / 1ps

module tb_first_fit_block_allocator;
    import ffba_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int N_SEGMENTS  = 8;
    localparam int SEG_ITEMS   = 200;

    typedef struct {
        logic [1:0]   cmd;
        int unsigned  req;
        int unsigned  off;
        bit           typed;
        ffba_result_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = '0;
    logic [16:0] request_size = '0;
    logic [15:0] block_offset = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        ok;
    logic [15:0] payload_offset;
    logic [16:0] granted_size;
    logic [1:0]  error_code;
    logic        zero_fill;
    logic [16:0] used_bytes;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    // allocator model state
    size_t       blk_size [STORE_DEPTH];
    link_t       blk_next [STORE_DEPTH];
    link_t       blk_prev [STORE_DEPTH];
    bit          blk_used [STORE_DEPTH];
    link_t       head_slot;
    int unsigned used_total;
    int unsigned pool_bytes;
    bit          clear_fill;

    ffba_result_t pending_results[$];
    int unsigned  live_offsets[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           mismatches = 0;
    int           results_seen = 0;
    int           frag_seen = 0;
    int           overrun_seen = 0;
    int           bad_free_seen = 0;
    int           cycle_count = 0;
    dir_row_t     rows[$];

    first_fit_block_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .request_size(request_size), .block_offset(block_offset),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .payload_offset(payload_offset), .granted_size(granted_size),
        .error_code(error_code), .zero_fill(zero_fill), .used_bytes(used_bytes),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_first_fit_block_allocator: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    function automatic ffba_result_t mk_res(logic okv, int unsigned po, int unsigned gs,
                                            logic [1:0] ec, logic zf, int unsigned ub);
        ffba_result_t r;
        r.ok = okv;
        r.payload_offset = off_t'(po);
        r.granted_size = size_t'(gs);
        r.error_code = ec;
        r.zero_fill = zf;
        r.used_bytes = size_t'(ub);
        return r;
    endfunction

    task automatic rebuild_pool();
        for (int i = 0; i < STORE_DEPTH; i++)
            blk_used[i] = 1'b0;
        used_total = 0;
        head_slot = '0;
        blk_size[0] = size_t'(pool_bytes - HEADER_BYTES);
        blk_next[0] = NO_BLOCK;
        blk_prev[0] = NO_BLOCK;
    endtask

    task automatic unlink_block(int unsigned s);
        link_t n;
        link_t p;
        n = blk_next[s];
        p = blk_prev[s];
        if (n != NO_BLOCK) blk_prev[n] = p;
        if (p != NO_BLOCK) blk_next[p] = n;
        else if (head_slot == link_t'(s)) head_slot = n;
        blk_next[s] = NO_BLOCK;
        blk_prev[s] = NO_BLOCK;
    endtask

    task automatic allocate_block(int unsigned req, bit zeroed, inout ffba_result_t r);
        int unsigned want, s, steps, hdr, leftover, rs;
        link_t n;
        link_t p;
        want = ((req + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        s = head_slot;
        steps = 0;
        while (s != NO_BLOCK && steps < STORE_DEPTH && blk_size[s] < want)
        begin
            s = blk_next[s];
            steps++;
        end
        if (s == NO_BLOCK || steps >= STORE_DEPTH)
        begin
            r.error_code = ((pool_bytes - used_total) > req) ? ERR_FRAG : ERR_OVERRUN;
            return;
        end
        hdr = s * SLOT_GRAIN;
        leftover = blk_size[s] - want;
        if (leftover > HEADER_BYTES)
        begin
            rs = (hdr + HEADER_BYTES + want) / SLOT_GRAIN;
            n = blk_next[s];
            p = blk_prev[s];
            blk_size[rs] = size_t'(leftover - HEADER_BYTES);
            blk_next[rs] = n;
            blk_prev[rs] = p;
            if (n != NO_BLOCK) blk_prev[n] = link_t'(rs);
            if (p != NO_BLOCK) blk_next[p] = link_t'(rs);
            if (head_slot == link_t'(s)) head_slot = link_t'(rs);
            blk_next[s] = NO_BLOCK;
            blk_prev[s] = NO_BLOCK;
            blk_size[s] = size_t'(want);
        end
        else
            unlink_block(s);
        blk_used[s] = 1'b1;
        used_total += HEADER_BYTES + blk_size[s];
        r.ok = 1'b1;
        r.payload_offset = off_t'(hdr + HEADER_BYTES);
        r.granted_size = blk_size[s];
        r.zero_fill = zeroed | clear_fill;
    endtask

    task automatic release_block(int unsigned off, inout ffba_result_t r);
        int unsigned hdr, f, n, nx, steps;
        if (off < HEADER_BYTES || (off - HEADER_BYTES) >= pool_bytes
            || ((off - HEADER_BYTES) % SLOT_GRAIN) != 0
            || !blk_used[(off - HEADER_BYTES) / SLOT_GRAIN])
        begin
            r.error_code = ERR_BAD_FREE;
            return;
        end
        hdr = off - HEADER_BYTES;
        f = hdr / SLOT_GRAIN;
        blk_used[f] = 1'b0;
        used_total -= HEADER_BYTES + blk_size[f];
        n = head_slot;
        steps = 0;
        // merge with every physically adjacent free block on the list
        while (n != NO_BLOCK && steps < STORE_DEPTH)
        begin
            nx = blk_next[n];
            if (f * SLOT_GRAIN + HEADER_BYTES + blk_size[f] == n * SLOT_GRAIN)
            begin
                blk_size[f] = size_t'(blk_size[f] + HEADER_BYTES + blk_size[n]);
                unlink_block(n);
            end
            else if (n * SLOT_GRAIN + HEADER_BYTES + blk_size[n] == f * SLOT_GRAIN)
            begin
                blk_size[n] = size_t'(blk_size[n] + HEADER_BYTES + blk_size[f]);
                unlink_block(n);
                f = n;
            end
            n = nx;
            steps++;
        end
        blk_next[f] = head_slot;
        blk_prev[f] = NO_BLOCK;
        if (head_slot != NO_BLOCK) blk_prev[head_slot] = link_t'(f);
        head_slot = link_t'(f);
        r.ok = 1'b1;
    endtask

    task automatic predict_request(logic [1:0] c, int unsigned req, int unsigned off,
                                   output ffba_result_t r);
        r = '0;
        if (c == CMD_ALLOC || c == CMD_ALLOC_ZERO)
            allocate_block(req, c == CMD_ALLOC_ZERO, r);
        else if (c == CMD_FREE)
            release_block(off, r);
        r.used_bytes = size_t'(used_total);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_request(logic [1:0] c, int unsigned req, int unsigned off,
                                bit typed, ffba_result_t typed_res);
        ffba_result_t r;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        request_size <= 17'(req);
        block_offset <= 16'(off);
        do @(posedge clk); while (in_stall);
        predict_request(c, req, off, r);
        pending_results.push_back(typed ? typed_res : r);
        if (r.ok && c != CMD_FREE)
            live_offsets.push_back(r.payload_offset);
        if (r.ok && c == CMD_FREE)
            foreach (live_offsets[i])
                if (live_offsets[i] == off)
                begin
                    live_offsets.delete(i);
                    break;
                end
        @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, int unsigned value);
        int unsigned v;
        // every request yields a result, so an empty queue plus a short pause means idle
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (32) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 17'(value);
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_POOL_SIZE)
        begin
            v = value & 17'h1ffff;
            if (v < HEADER_BYTES) v = HEADER_BYTES;
            if (v > POOL_BYTES) v = POOL_BYTES;
            pool_bytes = v;
            rebuild_pool();
            live_offsets.delete();
        end
        else if (idx == CFG_CLEAR)
            clear_fill = value[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        ffba_result_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = mk_res(ok, payload_offset, granted_size, error_code, zero_fill, used_bytes);
            results_seen++;
            if (got.error_code == ERR_FRAG) frag_seen++;
            if (got.error_code == ERR_OVERRUN) overrun_seen++;
            if (got.error_code == ERR_BAD_FREE) bad_free_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result ok=%0d off=%0d size=%0d err=%0d zf=%0d used=%0d",
                             ok, payload_offset, granted_size, error_code, zero_fill,
                             used_bytes);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ok=%0d off=%0d size=%0d err=%0d zf=%0d used=%0d | got ok=%0d off=%0d size=%0d err=%0d zf=%0d used=%0d",
                                 want.ok, want.payload_offset, want.granted_size,
                                 want.error_code, want.zero_fill, want.used_bytes,
                                 ok, payload_offset, granted_size, error_code, zero_fill,
                                 used_bytes);
                end
            end
        end
    end

    task automatic random_request();
        int unsigned pick, req, off, cap;
        logic [1:0] c;
        pick = $urandom_range(0, 99);
        cap = (pool_bytes / 6 > 512) ? 512 : pool_bytes / 6;
        if (live_offsets.size() > 40 && pick < 50)
            pick = 60;
        if (pick < 48)
        begin
            c = ($urandom_range(0, 1) == 1) ? CMD_ALLOC_ZERO : CMD_ALLOC;
            if ($urandom_range(0, 19) == 0)
                req = $urandom_range(0, 65536);
            else
                req = $urandom_range(0, cap);
            send_request(c, req, $urandom_range(0, 65535), 1'b0, '0);
        end
        else if (pick < 90 && live_offsets.size() > 0)
        begin
            off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
            send_request(CMD_FREE, $urandom_range(0, 65536), off, 1'b0, '0);
        end
        else if (pick < 97)
        begin
            // near misses, stale offsets and plain noise
            case ($urandom_range(0, 2))
                0: off = $urandom_range(0, 65535);
                1: off = live_offsets.size() > 0 ? live_offsets[0] + 8 : 24;
                default: off = $urandom_range(0, pool_bytes / 8) * 8;
            endcase
            send_request(CMD_FREE, $urandom_range(0, 65536), off & 16'hffff, 1'b0, '0);
        end
        else
            send_request(2'd3, $urandom_range(0, 65536), $urandom_range(0, 65535), 1'b0, '0);
    endtask

    initial
    begin
        int unsigned pool_plan [N_SEGMENTS];
        pool_plan = '{65536, 16, 1024, 131071, 300, 2048, 8, 4096};
        pool_bytes = POOL_BYTES;
        clear_fill = 1'b0;
        rebuild_pool();

        // known results right after reset, then ones left to the model
        rows.push_back('{CMD_ALLOC, 0, 0, 1, mk_res(1, 16, 0, ERR_NONE, 0, 16)});
        rows.push_back('{CMD_ALLOC_ZERO, 1, 0, 1, mk_res(1, 32, 8, ERR_NONE, 1, 40)});
        rows.push_back('{CMD_ALLOC, 65536, 0, 1, mk_res(0, 0, 0, ERR_OVERRUN, 0, 40)});
        rows.push_back('{CMD_ALLOC_ZERO, 131071, 0, 1, mk_res(0, 0, 0, ERR_OVERRUN, 0, 40)});
        rows.push_back('{CMD_FREE, 0, 0, 1, mk_res(0, 0, 0, ERR_BAD_FREE, 0, 40)});
        rows.push_back('{CMD_FREE, 0, 8, 1, mk_res(0, 0, 0, ERR_BAD_FREE, 0, 40)});
        rows.push_back('{CMD_FREE, 0, 65535, 1, mk_res(0, 0, 0, ERR_BAD_FREE, 0, 40)});
        rows.push_back('{CMD_FREE, 0, 20, 1, mk_res(0, 0, 0, ERR_BAD_FREE, 0, 40)});
        rows.push_back('{2'd3, 65535, 65535, 1, mk_res(0, 0, 0, ERR_NONE, 0, 40)});
        rows.push_back('{CMD_FREE, 0, 16, 0, '0});
        rows.push_back('{CMD_FREE, 0, 16, 0, '0});
        rows.push_back('{CMD_ALLOC, 7, 0, 0, '0});
        rows.push_back('{CMD_ALLOC, 100, 0, 0, '0});
        rows.push_back('{CMD_ALLOC, 9, 0, 0, '0});
        rows.push_back('{CMD_FREE, 0, 64, 0, '0});
        rows.push_back('{CMD_ALLOC, 40000, 0, 0, '0});
        rows.push_back('{CMD_ALLOC, 30000, 0, 0, '0});
        rows.push_back('{CMD_FREE, 0, 32, 0, '0});
        rows.push_back('{CMD_FREE, 0, 16, 0, '0});
        rows.push_back('{CMD_FREE, 0, 40, 0, '0});
        rows.push_back('{CMD_ALLOC, 65520, 0, 0, '0});
        rows.push_back('{CMD_ALLOC, 0, 0, 0, '0});
        rows.push_back('{CMD_FREE, 0, 16, 0, '0});
        rows.push_back('{CMD_ALLOC, 65520, 0, 0, '0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_request(rows[i].cmd, rows[i].req, rows[i].off, rows[i].typed, rows[i].res);

        for (int seg = 0; seg < N_SEGMENTS; seg++)
        begin
            if (seg < 3)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 48;
            end
            else if (seg < 6)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_register(CFG_CLEAR, (seg == 0) ? 1 : (seg == 1) ? 0 : $urandom_range(0, 1));
            write_register(CFG_POOL_SIZE, pool_plan[seg]);
            for (int k = 0; k < SEG_ITEMS; k++)
                random_request();
        end
        in_valid <= 1'b0;

        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d results over %0d pool settings: %0d fragmentation, %0d overrun, %0d invalid free",
                 results_seen, N_SEGMENTS + 1, frag_seen, overrun_seen, bad_free_seen);
        $display("mismatches: %0d, results still pending: %0d", mismatches,
                 pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_first_fit_block_allocator: PASS");
        else
            $display("tb_first_fit_block_allocator: FAIL");
        $finish;
    end

endmodule

### filelist.f
design/ffba_pkg.sv
design/ffba_ram.sv
design/ffba_engine.sv
design/first_fit_block_allocator.sv
tb/sv/tb_first_fit_block_allocator.sv
